// ===== rtl/crd_pkg.sv =====
package crd_pkg;

  localparam int HISTORY_DEPTH_DEF = 16;

  localparam int FRAME_W = 64;
  localparam int BITS_W  = 7;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 22;
  localparam int MS_W    = 12;
  localparam int TOTAL_W = 32;
  localparam int AGE_W   = WIN_W;

  localparam logic [WIN_W-1:0] WINDOW_RESET = 22'd700000;

  // floor(age / 1000) == (age * MS_RECIP) >> MS_SHIFT for every age below 2**22
  localparam int               RECIP_W  = 23;
  localparam logic [RECIP_W-1:0] MS_RECIP = 23'd4294968;
  localparam int               MS_SHIFT = 32;
  localparam int               PROD_W   = AGE_W + RECIP_W;
  localparam int               QUOT_W   = PROD_W - MS_SHIFT;
  localparam logic [MS_W-1:0]  MS_MAX   = 12'd4095;

  localparam logic [BITS_W-1:0] FRAME_MAX_BITS = 7'd64;
  localparam logic [BITS_W-1:0] PARITY_BITS    = 7'd2;

  localparam logic REQ_OBSERVE = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  localparam logic KIND_PARITY = 1'b0;
  localparam logic KIND_REPLAY = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0] cred;
    logic [BITS_W-1:0]  bits;
    logic [TIME_W-1:0]  stamp;
  } crd_entry_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } crd_hctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } crd_state_t;

endpackage

// ===== rtl/credential_replay_detector.sv =====
// walk: an observed read scans every history entry in ST_SCAN, waits in ST_DRAIN until the
//   read, compare and ms stages are empty, then in ST_FINISH writes its entry and gives its
//   final alert beat, if any; a new read is taken only in ST_IDLE, after the walk ends
// a session reset is handled in ST_IDLE and does not raise busy
// at most one alert beat a cycle; the receiver cannot stall them
// rst_n (synchronous) empties the history, zeroes cursor and alert count, reloads the window
module credential_replay_detector #(
  parameter int HISTORY_DEPTH = crd_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic [crd_pkg::FRAME_W-1:0]   in_raw_frame,
  input  logic [crd_pkg::BITS_W-1:0]    in_bit_count,
  input  logic                          in_parity_good,
  input  logic [crd_pkg::TIME_W-1:0]    in_time_us,
  output logic                          out_valid,
  output logic                          out_alert_kind,
  output logic [crd_pkg::MS_W-1:0]      out_age_ms,
  output logic [crd_pkg::BITS_W-1:0]    out_frame_bits,
  output logic [crd_pkg::FRAME_W-1:0]   out_payload,
  output logic [crd_pkg::TOTAL_W-1:0]   out_alert_total,
  output logic                          out_last_alert,
  input  logic                          cfg_we,
  input  logic [crd_pkg::WIN_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(HISTORY_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HISTORY_DEPTH - 1);

  crd_pkg::crd_state_t state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    cursor_r, cursor_nxt;
  logic [crd_pkg::TOTAL_W-1:0] counter_r, counter_nxt;
  logic [crd_pkg::WIN_W-1:0]   window_r, window_nxt;

  logic [crd_pkg::FRAME_W-1:0] cred_r, cred_nxt;
  logic [crd_pkg::BITS_W-1:0]  bits_r, bits_nxt;
  logic [crd_pkg::TIME_W-1:0]  time_r, time_nxt;

  logic                        pend_v_r, pend_v_nxt;
  logic                        pend_kind_r, pend_kind_nxt;
  logic [crd_pkg::MS_W-1:0]    pend_ms_r, pend_ms_nxt;
  logic [crd_pkg::TOTAL_W-1:0] pend_total_r, pend_total_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_kind_r, out_kind_nxt;
  logic [crd_pkg::MS_W-1:0]    out_ms_r, out_ms_nxt;
  logic [crd_pkg::TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        hit_r, hit_nxt;
  logic [crd_pkg::AGE_W-1:0]   age_r, age_nxt;
  logic [crd_pkg::TIME_W-1:0]  age_full;

  crd_pkg::crd_hctl_t  hctl;
  crd_pkg::crd_entry_t wr_entry;
  crd_pkg::crd_entry_t rd_entry;
  logic                rd_valid;
  logic                ms_valid;
  logic [crd_pkg::MS_W-1:0] ms_val;

  logic [crd_pkg::BITS_W-1:0]  n_bits;
  logic [crd_pkg::FRAME_W-1:0] cred_mask;
  logic [crd_pkg::FRAME_W-1:0] in_cred;

  // credential: frame without its leading and trailing parity bits
  always_comb begin
    n_bits    = (in_bit_count > crd_pkg::FRAME_MAX_BITS) ? crd_pkg::FRAME_MAX_BITS
                                                         : in_bit_count;
    cred_mask = (64'd1 << (n_bits - crd_pkg::PARITY_BITS)) - 64'd1;
    if (n_bits <= crd_pkg::PARITY_BITS) begin
      in_cred = '0;
    end else begin
      in_cred = (in_raw_frame >> 1) & cred_mask;
    end
  end

  assign wr_entry = '{cred: cred_r, bits: bits_r, stamp: time_r};

  crd_history #(
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (hctl),
    .rd_addr  (idx_r),
    .wr_addr  (cursor_r),
    .wr_data  (wr_entry),
    .rd_valid (rd_valid),
    .rd_data  (rd_entry)
  );

  // compare stage
  always_comb begin
    age_full = time_r - rd_entry.stamp;
    age_nxt  = age_full[crd_pkg::AGE_W-1:0];
    hit_nxt  = rd_valid && (rd_entry.bits == bits_r) && (rd_entry.cred == cred_r) &&
               (age_full < crd_pkg::TIME_W'(window_r));
  end

  crd_ms_conv u_ms_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (hit_r),
    .age_us    (age_r),
    .out_valid (ms_valid),
    .ms        (ms_val)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= crd_pkg::ST_IDLE;
      idx_r       <= '0;
      cursor_r    <= '0;
      counter_r   <= '0;
      window_r    <= crd_pkg::WINDOW_RESET;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      cursor_r    <= cursor_nxt;
      counter_r   <= counter_nxt;
      window_r    <= window_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cred_r       <= cred_nxt;
    bits_r       <= bits_nxt;
    time_r       <= time_nxt;
    pend_kind_r  <= pend_kind_nxt;
    pend_ms_r    <= pend_ms_nxt;
    pend_total_r <= pend_total_nxt;
    out_kind_r   <= out_kind_nxt;
    out_ms_r     <= out_ms_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
    age_r        <= age_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    cursor_nxt     = cursor_r;
    counter_nxt    = counter_r;
    window_nxt     = cfg_we ? cfg_wdata : window_r;
    cred_nxt       = cred_r;
    bits_nxt       = bits_r;
    time_nxt       = time_r;
    pend_v_nxt     = pend_v_r;
    pend_kind_nxt  = pend_kind_r;
    pend_ms_nxt    = pend_ms_r;
    pend_total_nxt = pend_total_r;
    out_valid_nxt  = 1'b0;
    out_kind_nxt   = out_kind_r;
    out_ms_nxt     = out_ms_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    hctl           = '0;

    unique case (state_r)
      crd_pkg::ST_IDLE: begin
        if (start) begin
          if (in_req_type == crd_pkg::REQ_CLEAR) begin
            hctl.clear  = 1'b1;
            cursor_nxt  = '0;
            counter_nxt = '0;
          end else begin
            cred_nxt       = in_cred;
            bits_nxt       = in_bit_count;
            time_nxt       = in_time_us;
            pend_v_nxt     = !in_parity_good;
            pend_kind_nxt  = crd_pkg::KIND_PARITY;
            pend_ms_nxt    = '0;
            pend_total_nxt = counter_r + 1'b1;
            if (!in_parity_good) begin
              counter_nxt = counter_r + 1'b1;
            end
            idx_nxt   = '0;
            state_nxt = crd_pkg::ST_SCAN;
          end
        end
      end
      crd_pkg::ST_SCAN: begin
        hctl.rd_en = 1'b1;
        idx_nxt    = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = crd_pkg::ST_DRAIN;
        end
      end
      crd_pkg::ST_DRAIN: begin
        if (!rd_valid && !hit_r && !ms_valid) begin
          state_nxt = crd_pkg::ST_FINISH;
        end
      end
      crd_pkg::ST_FINISH: begin
        out_valid_nxt = pend_v_r;
        out_kind_nxt  = pend_kind_r;
        out_ms_nxt    = pend_ms_r;
        out_total_nxt = pend_total_r;
        out_last_nxt  = 1'b1;
        pend_v_nxt    = 1'b0;
        hctl.wr_en    = 1'b1;
        cursor_nxt    = (cursor_r == LAST_IDX) ? '0 : cursor_r + 1'b1;
        state_nxt     = crd_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = crd_pkg::ST_IDLE;
      end
    endcase

    // a new replay hit pushes the held alert out, knowing it is not the last
    if (ms_valid) begin
      out_valid_nxt  = pend_v_r;
      out_kind_nxt   = pend_kind_r;
      out_ms_nxt     = pend_ms_r;
      out_total_nxt  = pend_total_r;
      out_last_nxt   = 1'b0;
      pend_v_nxt     = 1'b1;
      pend_kind_nxt  = crd_pkg::KIND_REPLAY;
      pend_ms_nxt    = ms_val;
      pend_total_nxt = counter_r + 1'b1;
      counter_nxt    = counter_r + 1'b1;
    end
  end

  assign busy            = (state_r != crd_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_alert_kind  = out_kind_r;
  assign out_age_ms      = out_ms_r;
  assign out_frame_bits  = bits_r;
  assign out_payload     = cred_r;
  assign out_alert_total = out_total_r;
  assign out_last_alert  = out_last_r;

  a_beat_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("alert beat outside a history walk");

  a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_alert |-> !busy)
    else $error("final alert beat while still busy");

  a_hit_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    ms_valid |-> (state_r == crd_pkg::ST_SCAN) || (state_r == crd_pkg::ST_DRAIN))
    else $error("replay hit outside the walk");

  a_clear_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == crd_pkg::REQ_CLEAR) |=> !busy && !out_valid)
    else $error("session reset started a walk");

endmodule

// ===== rtl/crd_history.sv =====
module crd_history #(
  parameter int DEPTH = crd_pkg::HISTORY_DEPTH_DEF,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  crd_pkg::crd_hctl_t  ctl,
  input  logic [IDX_W-1:0]    rd_addr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  crd_pkg::crd_entry_t wr_data,
  output logic                rd_valid,
  output crd_pkg::crd_entry_t rd_data
);

  crd_pkg::crd_entry_t mem [DEPTH];
  crd_pkg::crd_entry_t rd_data_r;
  logic [DEPTH-1:0]    vld_r;
  logic                rd_vbit_r;
  logic                rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vbit_r <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= ctl.rd_en;
    end
  end

  // never-written entries read as the cleared value
  assign rd_data  = rd_vbit_r ? rd_data_r : '0;
  assign rd_valid = rd_valid_r;

endmodule

// ===== rtl/crd_ms_conv.sv =====
module crd_ms_conv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [crd_pkg::AGE_W-1:0] age_us,
  output logic                      out_valid,
  output logic [crd_pkg::MS_W-1:0]  ms
);

  logic [crd_pkg::PROD_W-1:0] prod;
  logic [crd_pkg::QUOT_W-1:0] quot;
  logic [crd_pkg::MS_W-1:0]   ms_nxt;
  logic [crd_pkg::MS_W-1:0]   ms_r;
  logic                       out_valid_r;

  always_comb begin
    prod = crd_pkg::PROD_W'(age_us) * crd_pkg::PROD_W'(crd_pkg::MS_RECIP);
    quot = prod[crd_pkg::PROD_W-1:crd_pkg::MS_SHIFT];
    if (quot > crd_pkg::QUOT_W'(crd_pkg::MS_MAX)) begin
      ms_nxt = crd_pkg::MS_MAX;
    end else begin
      ms_nxt = quot[crd_pkg::MS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ms_r <= ms_nxt;
  end

  assign out_valid = out_valid_r;
  assign ms        = ms_r;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int HISTORY_DEPTH = crd_pkg::HISTORY_DEPTH_DEF;
  localparam int IDLE_LIMIT    = 3000;
  localparam int POOL_N        = 8;
  localparam logic [crd_pkg::WIN_W-1:0] WIN_FULL = '1;

  typedef struct {
    logic                        req;
    logic [crd_pkg::FRAME_W-1:0] raw;
    logic [crd_pkg::BITS_W-1:0]  bits;
    logic                        par_ok;
    logic [crd_pkg::TIME_W-1:0]  t_us;
  } read_t;

  typedef struct packed {
    logic                        kind;
    logic [crd_pkg::MS_W-1:0]    age_ms;
    logic [crd_pkg::BITS_W-1:0]  bits;
    logic [crd_pkg::FRAME_W-1:0] cred;
    logic [crd_pkg::TOTAL_W-1:0] total;
    logic                        last;
  } alert_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         in_req_type = crd_pkg::REQ_OBSERVE;
  logic [crd_pkg::FRAME_W-1:0]  in_raw_frame = '0;
  logic [crd_pkg::BITS_W-1:0]   in_bit_count = '0;
  logic                         in_parity_good = 1'b1;
  logic [crd_pkg::TIME_W-1:0]   in_time_us = '0;
  logic                         out_valid;
  logic                         out_alert_kind;
  logic [crd_pkg::MS_W-1:0]     out_age_ms;
  logic [crd_pkg::BITS_W-1:0]   out_frame_bits;
  logic [crd_pkg::FRAME_W-1:0]  out_payload;
  logic [crd_pkg::TOTAL_W-1:0]  out_alert_total;
  logic                         out_last_alert;
  logic                         cfg_we = 1'b0;
  logic [crd_pkg::WIN_W-1:0]    cfg_wdata = '0;

  credential_replay_detector u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_req_type     (in_req_type),
    .in_raw_frame    (in_raw_frame),
    .in_bit_count    (in_bit_count),
    .in_parity_good  (in_parity_good),
    .in_time_us      (in_time_us),
    .out_valid       (out_valid),
    .out_alert_kind  (out_alert_kind),
    .out_age_ms      (out_age_ms),
    .out_frame_bits  (out_frame_bits),
    .out_payload     (out_payload),
    .out_alert_total (out_alert_total),
    .out_last_alert  (out_last_alert),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // history mirror
  logic [crd_pkg::FRAME_W-1:0] hist_cred [HISTORY_DEPTH];
  logic [crd_pkg::BITS_W-1:0]  hist_bits [HISTORY_DEPTH];
  logic [crd_pkg::TIME_W-1:0]  hist_time [HISTORY_DEPTH];
  int unsigned                 hist_slot;
  logic [crd_pkg::TOTAL_W-1:0] alert_count;
  logic [crd_pkg::WIN_W-1:0]   win_model = crd_pkg::WINDOW_RESET;

  read_t  read_q [$];
  alert_t alert_q [$];

  logic [crd_pkg::FRAME_W-1:0] pool_raw [POOL_N];
  logic [crd_pkg::BITS_W-1:0]  pool_bits [POOL_N];
  logic [crd_pkg::TIME_W-1:0]  cur_us;

  int n_obs, n_clear, n_parity, n_replay, n_sat, n_err, n_windows;
  int idle_cycles;

  task automatic clear_history();
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      hist_cred[i] = '0;
      hist_bits[i] = '0;
      hist_time[i] = '0;
    end
    hist_slot   = 0;
    alert_count = '0;
  endtask

  task automatic score_read(input read_t r);
    logic [crd_pkg::FRAME_W-1:0] cred;
    logic [crd_pkg::TIME_W-1:0]  age;
    logic [crd_pkg::TIME_W-1:0]  ms;
    logic [HISTORY_DEPTH-1:0]    hit;
    alert_t a;
    int n, left;
    if (r.req == crd_pkg::REQ_CLEAR) begin
      clear_history();
      n_clear++;
      return;
    end
    n_obs++;
    n = (r.bits > crd_pkg::FRAME_MAX_BITS) ? crd_pkg::FRAME_W : int'(r.bits);
    cred = (n <= 2) ? '0 : ((r.raw >> 1) & ((64'd1 << (n - 2)) - 64'd1));
    hit  = '0;
    left = r.par_ok ? 0 : 1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      age = r.t_us - hist_time[i];
      if (hist_bits[i] == r.bits && hist_cred[i] == cred && age < {10'd0, win_model}) begin
        hit[i] = 1'b1;
        left++;
      end
    end
    if (!r.par_ok) begin
      alert_count++;
      left--;
      a = '{crd_pkg::KIND_PARITY, '0, r.bits, cred, alert_count, left == 0};
      alert_q.push_back(a);
    end
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (hit[i]) begin
        age = r.t_us - hist_time[i];
        ms  = age / 1000;
        if (ms > 4095) ms = 4095;
        alert_count++;
        left--;
        a = '{crd_pkg::KIND_REPLAY, ms[crd_pkg::MS_W-1:0], r.bits, cred, alert_count,
              left == 0};
        alert_q.push_back(a);
      end
    end
    hist_cred[hist_slot] = cred;
    hist_bits[hist_slot] = r.bits;
    hist_time[hist_slot] = r.t_us;
    hist_slot = (hist_slot + 1) % HISTORY_DEPTH;
  endtask

  function automatic int draw_gap();
    int s;
    s = $urandom_range(0, 99);
    if (s < 55) return 0;
    if (s < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [crd_pkg::BITS_W-1:0] pick_bits();
    int s;
    s = $urandom_range(0, 99);
    if (s < 75) return crd_pkg::BITS_W'($urandom_range(3, 64));
    if (s < 85) return crd_pkg::BITS_W'($urandom_range(0, 2));
    return crd_pkg::BITS_W'($urandom_range(65, 127));
  endfunction

  task automatic add_read(input logic req, input logic [crd_pkg::FRAME_W-1:0] raw,
                          input logic [crd_pkg::BITS_W-1:0] bits, input logic par_ok,
                          input logic [crd_pkg::TIME_W-1:0] t_us);
    read_t r;
    r = '{req, raw, bits, par_ok, t_us};
    read_q.push_back(r);
  endtask

  // mostly repeats from a small credential pool so the ring sees hits
  task automatic gen_reads(input int count);
    read_t r;
    logic [crd_pkg::FRAME_W-1:0] keep;
    logic [crd_pkg::TIME_W-1:0]  scale;
    logic [crd_pkg::TIME_W-1:0]  dt;
    int sel, p, n;
    for (p = 0; p < POOL_N; p++) begin
      pool_raw[p]  = {$urandom, $urandom};
      pool_bits[p] = pick_bits();
    end
    scale = (win_model > 2000) ? {10'd0, win_model} : 32'd2000;
    for (int k = 0; k < count; k++) begin
      sel      = $urandom_range(0, 99);
      r.req    = crd_pkg::REQ_OBSERVE;
      r.raw    = {$urandom, $urandom};
      r.bits   = pick_bits();
      r.par_ok = ($urandom_range(0, 99) < 88);
      if (sel < 4) begin
        r.req = crd_pkg::REQ_CLEAR;
        r.bits = crd_pkg::BITS_W'($urandom_range(0, 127));
      end else if (sel < 64) begin
        p = $urandom_range(0, POOL_N - 1);
        r.bits = pool_bits[p];
        n = (r.bits > crd_pkg::FRAME_MAX_BITS) ? crd_pkg::FRAME_W : int'(r.bits);
        keep = (n > 2) ? (((64'd1 << (n - 2)) - 64'd1) << 1) : '0;
        r.raw = (pool_raw[p] & keep) | (r.raw & ~keep);
      end else if (sel < 70) begin
        r.raw  = '0;
        r.bits = '0;
      end
      sel = $urandom_range(0, 99);
      if (sel < 15) dt = 0;
      else if (sel < 55) dt = $urandom_range(0, scale / 16);
      else if (sel < 85) dt = $urandom_range(0, scale / 2);
      else if (sel < 95) dt = $urandom_range(0, scale * 2);
      else dt = $urandom;
      cur_us = cur_us + dt;
      r.t_us = (r.req == crd_pkg::REQ_CLEAR) ? $urandom : cur_us;
      read_q.push_back(r);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (read_q.size() != 0 || start || busy || alert_q.size() != 0) @(negedge clk);
    repeat (HISTORY_DEPTH + 8) @(posedge clk);
  endtask

  task automatic set_window(input logic [crd_pkg::WIN_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    win_model = v;
    n_windows++;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // driver
  read_t cur_read;
  int    gap_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) score_read(cur_read);
      if (start && busy) begin
        // hold the beat until taken
      end else if (gap_left != 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (read_q.size() != 0) begin
        cur_read = read_q.pop_front();
        in_req_type    <= cur_read.req;
        in_raw_frame   <= cur_read.raw;
        in_bit_count   <= cur_read.bits;
        in_parity_good <= cur_read.par_ok;
        in_time_us     <= cur_read.t_us;
        start          <= 1'b1;
        gap_left = draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    alert_t want;
    if (rst_n && out_valid) begin
      if (alert_q.size() == 0) begin
        if (n_err < 10)
          $display("unexpected alert beat: kind %0d age %0d bits %0d payload %h total %0d",
                   out_alert_kind, out_age_ms, out_frame_bits, out_payload, out_alert_total);
        n_err++;
      end else begin
        want = alert_q.pop_front();
        if (want.kind == crd_pkg::KIND_REPLAY) n_replay++;
        else n_parity++;
        if (want.age_ms == crd_pkg::MS_MAX) n_sat++;
        if (out_alert_kind !== want.kind || out_age_ms !== want.age_ms ||
            out_frame_bits !== want.bits || out_payload !== want.cred ||
            out_alert_total !== want.total || out_last_alert !== want.last) begin
          if (n_err < 10)
            $display({"alert mismatch (exp/got): kind %0d/%0d age %0d/%0d bits %0d/%0d ",
                      "payload %h/%h total %0d/%0d last %0d/%0d"},
                     want.kind, out_alert_kind, want.age_ms, out_age_ms,
                     want.bits, out_frame_bits, want.cred, out_payload,
                     want.total, out_alert_total, want.last, out_last_alert);
          n_err++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("credential_replay_detector regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [crd_pkg::FRAME_W-1:0] ones;
    logic [crd_pkg::FRAME_W-1:0] alt;
    logic [crd_pkg::FRAME_W-1:0] cred_a;
    ones = '1;
    alt  = 64'hAAAA_AAAA_AAAA_AAAA;
    clear_history();
    n_obs = 0; n_clear = 0; n_parity = 0; n_replay = 0; n_sat = 0; n_err = 0;
    n_windows = 1;
    idle_cycles = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty ring: all-zero reads hit every cleared entry
    add_read(crd_pkg::REQ_OBSERVE, '0, 7'd0, 1'b1, 100);
    add_read(crd_pkg::REQ_OBSERVE, '0, 7'd0, 1'b0, 500);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd64, 1'b1, 1000);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd64, 1'b0, 700999);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd64, 1'b1, 1400999);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd65, 1'b1, 1401000);
    add_read(crd_pkg::REQ_OBSERVE, {$urandom, $urandom}, 7'd127, 1'b1, 1401010);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd1, 1'b0, 1401020);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd2, 1'b1, 1401030);
    add_read(crd_pkg::REQ_OBSERVE, '0, 7'd2, 1'b1, 1401040);
    add_read(crd_pkg::REQ_OBSERVE, ones, 7'd3, 1'b1, 1401050);
    // timestamp wraps between the two reads
    add_read(crd_pkg::REQ_OBSERVE, alt, 7'd34, 1'b1, 32'hFFFF_FF00);
    add_read(crd_pkg::REQ_OBSERVE, alt, 7'd34, 1'b1, 32'h0000_0100);
    add_read(crd_pkg::REQ_OBSERVE, ~alt, 7'd37, 1'b0, 32'h0000_0200);
    add_read(crd_pkg::REQ_CLEAR, {$urandom, $urandom},
             crd_pkg::BITS_W'($urandom_range(0, 127)), 1'b0, $urandom);
    add_read(crd_pkg::REQ_OBSERVE, ~alt, 7'd37, 1'b0, 300);
    add_read(crd_pkg::REQ_OBSERVE, '0, 7'd0, 1'b1, 800000);
    add_read(crd_pkg::REQ_OBSERVE, '0, 7'd0, 1'b1, 800100);
    cur_us = 900000;
    gen_reads(70);
    drain();

    set_window(22'd1);
    gen_reads(60);
    drain();

    // widest window: ages past 4095 ms saturate
    set_window(WIN_FULL);
    cred_a = {$urandom, $urandom};
    add_read(crd_pkg::REQ_OBSERVE, cred_a, 7'd40, 1'b1, 32'h1000_0000);
    add_read(crd_pkg::REQ_OBSERVE, cred_a, 7'd40, 1'b1, 32'h1000_0000 + 4100000);
    add_read(crd_pkg::REQ_OBSERVE, cred_a, 7'd40, 1'b0, 32'h1000_0000 + 4194302);
    cur_us = 32'h2000_0000;
    gen_reads(70);
    drain();

    // zero window never flags a replay
    set_window('0);
    add_read(crd_pkg::REQ_OBSERVE, cred_a, 7'd50, 1'b1, cur_us);
    add_read(crd_pkg::REQ_OBSERVE, cred_a, 7'd50, 1'b1, cur_us);
    gen_reads(50);
    drain();

    set_window(22'd4000000);
    gen_reads(70);
    drain();

    set_window(crd_pkg::WIN_W'($urandom_range(1, 4000000)));
    gen_reads(50);
    drain();

    set_window(22'd250000);
    gen_reads(50);
    drain();

    if (alert_q.size() != 0) n_err++;
    $display("run covered %0d card reads and %0d session clears over %0d window settings",
             n_obs, n_clear, n_windows);
    $display("alert beats checked: %0d parity, %0d replay (%0d with saturated age), %0d errors",
             n_parity, n_replay, n_sat, n_err);
    if (n_err == 0) begin
      $display("credential_replay_detector regression: pass");
    end else begin
      $display("credential_replay_detector regression: fail");
    end
    $finish;
  end

endmodule
